@@ rtl/core/ahec_pkg.sv @@
// Shared types, constants and fixed-point helpers for the accelerometer
// high-pass / moving-average capture block. No dependencies.
package ahec_pkg;

  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;
  localparam int OPA_W  = 34;
  localparam int OPB_W  = 17;
  localparam int PROD_W = 52;
  localparam int WIDE_W = 53;

  typedef struct packed {
    logic        mode;
    logic [15:0] word_x;
    logic [15:0] word_y;
    logic [15:0] word_z;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] smooth_x;
    logic signed [31:0] smooth_y;
    logic signed [31:0] smooth_z;
    logic               stored;
    logic [6:0]         slot;
  } result_t;

  typedef struct packed {
    logic [15:0] scale_q16;
    logic [15:0] highpass_coeff_q16;
    logic [15:0] smoothing_coeff_q16;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_SCALE     = 2'd0,
    REG_HIGHPASS  = 2'd1,
    REG_SMOOTHING = 2'd2
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_SUM,
    ST_HP,
    ST_Y,
    ST_AVG1,
    ST_AVG2,
    ST_AVG3,
    ST_DONE
  } state_t;

  localparam logic [15:0] SCALE_RESET     = 16'd5243;
  localparam logic [15:0] HIGHPASS_RESET  = 16'd55706;
  localparam logic [15:0] SMOOTHING_RESET = 16'd13107;
  localparam logic [1:0]  LAST_AXIS       = 2'd2;

  function automatic logic signed [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] max_v;
    logic signed [WIDE_W-1:0] min_v;
    max_v = WIDE_W'(64'sh7FFF_FFFF);
    min_v = WIDE_W'(-64'sh8000_0000);
    if (v > max_v) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < min_v) begin
      sat32 = -32'sh8000_0000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

  // add one half, floor-shift by 16, saturate
  function automatic logic signed [31:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [WIDE_W-1:0] t;
    t = WIDE_W'(p) + WIDE_W'(64'sd32768);
    round_sat = sat32(t >>> 16);
  endfunction

endpackage

@@ rtl/core/ahec_mul.sv @@
// Shared signed-by-unsigned multiplier with registered product.
// Depends on ahec_pkg.
module ahec_mul (
  input  logic                               clk,
  input  logic signed [ahec_pkg::OPA_W-1:0]  op_a,
  input  logic        [ahec_pkg::OPB_W-1:0]  op_b,
  output logic signed [ahec_pkg::PROD_W-1:0] prod
);
  import ahec_pkg::*;

  logic signed [PROD_W-1:0] a_ext;
  logic signed [PROD_W-1:0] b_ext;

  assign a_ext = PROD_W'(op_a);
  assign b_ext = $signed(PROD_W'(op_b));

  always_ff @(posedge clk) begin
    prod <= a_ext * b_ext;
  end

endmodule

@@ rtl/core/ahec_regs.sv @@
// APB-style configuration registers (scale, high-pass and smoothing coefficients).
// Depends on ahec_pkg.
module ahec_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ahec_pkg::ADDR_W-1:0] paddr,
  input  logic [ahec_pkg::DATA_W-1:0] pwdata,
  output logic [ahec_pkg::DATA_W-1:0] prdata,
  output ahec_pkg::cfg_t              cfg
);
  import ahec_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.scale_q16           <= SCALE_RESET;
      cfg.highpass_coeff_q16  <= HIGHPASS_RESET;
      cfg.smoothing_coeff_q16 <= SMOOTHING_RESET;
    end else if (wr) begin
      case (idx)
        REG_SCALE:     cfg.scale_q16           <= pwdata[15:0];
        REG_HIGHPASS:  cfg.highpass_coeff_q16  <= pwdata[15:0];
        REG_SMOOTHING: cfg.smoothing_coeff_q16 <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SCALE:     prdata = {16'd0, cfg.scale_q16};
      REG_HIGHPASS:  prdata = {16'd0, cfg.highpass_coeff_q16};
      REG_SMOOTHING: prdata = {16'd0, cfg.smoothing_coeff_q16};
      default:       prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/ahec_capture.sv @@
// Capture buffer: axis-major storage of smoothed samples, one write port.
// Depends on ahec_pkg.
module ahec_capture #(
  parameter int ENTRIES = 384
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [$clog2(ENTRIES)-1:0]   addr,
  input  logic signed [31:0]           wdata
);
  import ahec_pkg::*;

  logic signed [31:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

endmodule

@@ rtl/core/accel_hpf_ema_capture.sv @@
// Top level: sequencer and per-axis filter state around one shared multiplier.
// Depends on ahec_pkg, ahec_regs, ahec_mul, ahec_capture.
//
//  channel  | signals                               | dir | payload
//  ---------+---------------------------------------+-----+-------------------
//  sample   | sample_valid / sample_ready / sample  | in  | sample_t
//  result   | result_valid / result_ready / result  | out | result_t
//  config   | psel penable pwrite paddr pwdata ...  | in  | 3 x 16-bit regs
//
// Per axis, a sample takes four multiplier passes (scale, high-pass and the two
// average terms) plus three register stages; the three axes all go through the
// single multiplier, after which the result is loaded. A restart skips filtering
// and goes straight to the final state to load the result.
// The result sits in an output register; a stalled result holds the sequencer
// in its final state. Reset clears filter state, fill count and configuration registers.
module accel_hpf_ema_capture #(
  parameter int CAPTURE_DEPTH = 128,
  parameter int RIGHT_SHIFT   = 6
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        sample_valid,
  output logic                        sample_ready,
  input  ahec_pkg::sample_t           sample,
  output logic                        result_valid,
  input  logic                        result_ready,
  output ahec_pkg::result_t           result,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ahec_pkg::ADDR_W-1:0] paddr,
  input  logic [ahec_pkg::DATA_W-1:0] pwdata,
  output logic [ahec_pkg::DATA_W-1:0] prdata,
  output logic                        pready
);
  import ahec_pkg::*;

  localparam int CAP_ENTRIES = 3 * CAPTURE_DEPTH;
  localparam int CAP_AW      = $clog2(CAP_ENTRIES);
  localparam int FILL_W      = $clog2(CAPTURE_DEPTH + 1);

  cfg_t   cfg;
  state_t state, state_next;

  sample_t              smp;
  logic [1:0]           axis;
  logic                 store_en;
  logic [FILL_W-1:0]    fill_count;

  logic signed [31:0]   last_input      [3];
  logic signed [31:0]   last_highpass   [3];
  logic signed [31:0]   running_average [3];

  logic signed [31:0]       x_reg;
  logic signed [31:0]       y_reg;
  logic signed [OPA_W-1:0]  sum_reg;
  logic signed [PROD_W-1:0] acc_reg;

  logic signed [OPA_W-1:0]  op_a;
  logic        [OPB_W-1:0]  op_b;
  logic signed [PROD_W-1:0] prod;

  logic [15:0]          word_sel;
  logic signed [15:0]   raw;
  logic signed [31:0]   x_now;
  logic signed [31:0]   rounded;
  logic signed [31:0]   avg_now;
  logic                 accept;
  logic                 load_result;
  logic                 cap_we;
  logic [CAP_AW-1:0]    cap_addr;

  assign pready = 1'b1;

  ahec_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  ahec_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  ahec_capture #(
    .ENTRIES (CAP_ENTRIES)
  ) u_capture (
    .clk   (clk),
    .we    (cap_we),
    .addr  (cap_addr),
    .wdata (avg_now)
  );

  assign sample_ready = (state == ST_IDLE);
  assign accept       = sample_valid & sample_ready;

  always_comb begin
    case (axis)
      2'd0:    word_sel = smp.word_x;
      2'd1:    word_sel = smp.word_y;
      default: word_sel = smp.word_z;
    endcase
  end

  assign raw      = $signed(word_sel) >>> RIGHT_SHIFT;
  assign x_now    = sat32(WIDE_W'(prod));
  assign rounded  = round_sat(prod);
  assign avg_now  = round_sat(acc_reg + prod);
  assign cap_we   = (state == ST_AVG3) && store_en;
  assign cap_addr = CAP_AW'(axis * CAPTURE_DEPTH) + CAP_AW'(fill_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    op_a        = '0;
    op_b        = '0;
    load_result = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = sample.mode ? ST_DONE : ST_SCALE;
        end
      end
      ST_SCALE: begin
        op_a       = OPA_W'(raw);
        op_b       = {1'b0, cfg.scale_q16};
        state_next = ST_SUM;
      end
      ST_SUM: state_next = ST_HP;
      ST_HP: begin
        op_a       = sum_reg;
        op_b       = {1'b0, cfg.highpass_coeff_q16};
        state_next = ST_Y;
      end
      ST_Y: state_next = ST_AVG1;
      ST_AVG1: begin
        op_a       = OPA_W'(running_average[axis]);
        op_b       = OPB_W'(18'h10000 - {2'b0, cfg.smoothing_coeff_q16});
        state_next = ST_AVG2;
      end
      ST_AVG2: begin
        op_a       = OPA_W'(y_reg);
        op_b       = {1'b0, cfg.smoothing_coeff_q16};
        state_next = ST_AVG3;
      end
      ST_AVG3: state_next = (axis == LAST_AXIS) ? ST_DONE : ST_SCALE;
      ST_DONE: begin
        if (!result_valid || result_ready) begin
          load_result = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count   <= '0;
      store_en     <= 1'b0;
      axis         <= '0;
      result_valid <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        last_input[i]      <= '0;
        last_highpass[i]   <= '0;
        running_average[i] <= '0;
      end
    end else begin
      if (result_valid && result_ready && !load_result) begin
        result_valid <= 1'b0;
      end
      if (accept) begin
        axis <= '0;
        if (sample.mode) begin
          fill_count <= '0;
          store_en   <= 1'b0;
        end else begin
          store_en <= (32'(fill_count) < CAPTURE_DEPTH);
        end
      end
      if (state == ST_Y) begin
        last_input[axis]    <= x_reg;
        last_highpass[axis] <= rounded;
      end
      if (state == ST_AVG3) begin
        running_average[axis] <= avg_now;
        if (axis != LAST_AXIS) begin
          axis <= axis + 2'd1;
        end
      end
      if (load_result) begin
        result_valid <= 1'b1;
        if (store_en) begin
          fill_count <= fill_count + FILL_W'(1);
        end
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      smp <= sample;
    end
    if (state == ST_SUM) begin
      x_reg   <= x_now;
      sum_reg <= OPA_W'(last_highpass[axis]) + OPA_W'(x_now) - OPA_W'(last_input[axis]);
    end
    if (state == ST_Y) begin
      y_reg <= rounded;
    end
    if (state == ST_AVG2) begin
      acc_reg <= prod;
    end
    if (load_result) begin
      result.smooth_x <= running_average[0];
      result.smooth_y <= running_average[1];
      result.smooth_z <= running_average[2];
      result.stored   <= store_en;
      result.slot     <= store_en ? 7'(fill_count) : 7'd0;
    end
  end

endmodule
